[hw/rtl/ntc_beta_temperature_top_macros.svh]
// ----------------------------------------------------------------------------
// ntc beta temperature assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NTC_BETA_TEMPERATURE_TOP_MACROS_SVH
`define NTC_BETA_TEMPERATURE_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define NTCB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ntcb port check failed");

// next-cycle implication, disabled in reset
`define NTCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ntcb port check failed");

`endif

[hw/rtl/ntcb_pkg.sv]
// ----------------------------------------------------------------------------
// ntcb_pkg
// shared constants, register codes and log step table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ntcb_pkg;

    localparam int ADC_BITS = 12;
    localparam int OHM_W    = 20;
    localparam int CK_W     = 16;
    localparam int LN_W     = 23;
    localparam int M_W      = 18;
    localparam int ACC_W    = 17;
    localparam int K_W      = 5;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 3;
    localparam int TEMP_W   = 16;

    localparam logic [16:0]    LN2_Q16  = 17'd45426;
    localparam logic [M_W-1:0] TWO_Q16  = 18'd131072;
    localparam logic [16:0]    ABS_ZERO = 17'd27315;
    localparam logic [16:0]    Q_MAX    = 17'd60082;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -16'sd27315;

    typedef enum logic [IDX_W-1:0] {
        REG_FULL_SCALE = 3'd0,
        REG_PULLUP     = 3'd1,
        REG_NOMINAL    = 3'd2,
        REG_T0         = 3'd3,
        REG_BETA       = 3'd4
    } cfg_reg_t;

    function automatic logic [ACC_W-1:0] ln_step(input int i);
        logic [ACC_W-1:0] v;
        begin
            case (i)
                1:       v = 17'd26573;
                2:       v = 17'd14624;
                3:       v = 17'd7719;
                4:       v = 17'd3973;
                5:       v = 17'd2017;
                6:       v = 17'd1016;
                7:       v = 17'd510;
                8:       v = 17'd256;
                9:       v = 17'd128;
                10:      v = 17'd64;
                11:      v = 17'd32;
                12:      v = 17'd16;
                13:      v = 17'd8;
                14:      v = 17'd4;
                15:      v = 17'd2;
                16:      v = 17'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

[hw/rtl/ntc_beta_temperature_top.sv]
// path: log units, combine stages, divider, then the output register
// throughput: one request per cycle; the whole pipeline holds while the output stalls
// the cost sits in four 4-stage log units and a 17-stage restoring divider
// reset: synchronous active-low aresetn clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
// ntc_beta_temperature_top
// ntc thermistor beta equation, adc code to centidegrees celsius
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntc_beta_temperature_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [ntcb_pkg::IDX_W-1:0]           cfg_addr,
    input  logic [ntcb_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [ntcb_pkg::ADC_BITS-1:0]        s_sample_code,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ntcb_pkg::TEMP_W-1:0]   m_temperature_centi_c,
    output logic                                 m_out_of_range
);

    localparam int DIV_N = 17;
    localparam int REM_W = 58;

    logic [ntcb_pkg::ADC_BITS-1:0] full_reg;
    logic [ntcb_pkg::OHM_W-1:0]    pullup_reg, nominal_reg;
    logic [ntcb_pkg::CK_W-1:0]     t0_reg, beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg    <= '1;
            pullup_reg  <= 20'd10000;
            nominal_reg <= 20'd10000;
            t0_reg      <= 16'd29815;
            beta_reg    <= 16'd3950;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                ntcb_pkg::REG_FULL_SCALE: full_reg    <= cfg_wdata[ntcb_pkg::ADC_BITS-1:0];
                ntcb_pkg::REG_PULLUP:     pullup_reg  <= cfg_wdata[ntcb_pkg::OHM_W-1:0];
                ntcb_pkg::REG_NOMINAL:    nominal_reg <= cfg_wdata[ntcb_pkg::OHM_W-1:0];
                ntcb_pkg::REG_T0:         t0_reg      <= cfg_wdata[ntcb_pkg::CK_W-1:0];
                ntcb_pkg::REG_BETA:       beta_reg    <= cfg_wdata[ntcb_pkg::CK_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic m_valid_reg;
    logic signed [ntcb_pkg::TEMP_W-1:0] temp_reg;
    logic oor_out_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic [ntcb_pkg::CK_W-1:0] t0_eff, b_eff;
    assign t0_eff = (t0_reg == '0) ? ntcb_pkg::CK_W'(1) : t0_reg;
    assign b_eff  = (beta_reg == '0) ? ntcb_pkg::CK_W'(1) : beta_reg;

    // log front end
    logic in_oor;
    logic [ntcb_pkg::OHM_W-1:0] x_code, x_diff;
    logic signed [ntcb_pkg::LN_W-1:0] ln_p, ln_c, ln_d, ln_r;

    assign in_oor = (s_sample_code == '0) || (s_sample_code >= full_reg);
    assign x_code = ntcb_pkg::OHM_W'(s_sample_code);
    assign x_diff = ntcb_pkg::OHM_W'(full_reg - s_sample_code);

    ntcb_ln u_ln_p (.aclk(aclk), .en(en), .x(pullup_reg),  .ln_q16(ln_p));
    ntcb_ln u_ln_c (.aclk(aclk), .en(en), .x(x_code),      .ln_q16(ln_c));
    ntcb_ln u_ln_d (.aclk(aclk), .en(en), .x(x_diff),      .ln_q16(ln_d));
    ntcb_ln u_ln_r (.aclk(aclk), .en(en), .x(nominal_reg), .ln_q16(ln_r));

    logic [3:0] lv_reg, lo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lv_reg <= '0;
        end else if (en) begin
            lv_reg <= {lv_reg[2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lo_reg <= {lo_reg[2:0], in_oor};
        end
    end

    // log combine, products, numerator and denominator
    logic signed [23:0] l_reg, l_next;
    logic signed [40:0] lt_reg, lt_next;
    logic [31:0]        tb_reg, tb_next;
    logic signed [41:0] den_reg, den_next;
    logic [54:0]        num_reg, num_next;
    logic [2:0]         mv_reg, mo_reg;

    always_comb begin
        l_next   = 24'(ln_p) + 24'(ln_c) - 24'(ln_d) - 24'(ln_r);
        lt_next  = 41'(l_reg) * 41'($signed({1'b0, t0_eff}));
        tb_next  = 32'(t0_eff) * 32'(b_eff);
        den_next = $signed({3'b0, 23'(b_eff) * 23'd100, 16'b0}) + 42'(lt_reg);
        num_next = {39'(tb_reg) * 39'd100, 16'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= '0;
        end else if (en) begin
            mv_reg <= {mv_reg[1:0], lv_reg[3]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mo_reg  <= {mo_reg[1:0], lo_reg[3]};
            l_reg   <= l_next;
            lt_reg  <= lt_next;
            tb_reg  <= tb_next;
            den_reg <= den_next;
            num_reg <= num_next;
        end
    end

    // divider pipeline: index 0 is the set-up stage
    logic [REM_W-1:0] rem_reg [0:DIV_N];
    logic [REM_W-1:0] dv_reg  [0:DIV_N];
    logic [DIV_N-1:0] q_reg   [0:DIV_N];
    logic             sat_reg [0:DIV_N];
    logic             dov_reg [0:DIV_N];
    logic             dv_vld_reg [0:DIV_N];

    logic             den_pos;
    logic [REM_W-1:0] dv0, rem0;

    always_comb begin
        den_pos = !den_reg[41] && (den_reg != '0);
        dv0     = REM_W'(den_reg[40:0]);
        rem0    = REM_W'(num_reg) + REM_W'(den_reg[40:1]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_vld_reg[0] <= 1'b0;
        end else if (en) begin
            dv_vld_reg[0] <= mv_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem0;
            dv_reg[0]  <= dv0;
            q_reg[0]   <= '0;
            sat_reg[0] <= !den_pos || (rem0 >= (dv0 << DIV_N));
            dov_reg[0] <= mo_reg[2];
        end
    end

    for (genvar g = 0; g < DIV_N; g++) begin : g_div
        localparam int SH = DIV_N - 1 - g;
        logic [REM_W-1:0] trial;
        logic             take;
        assign trial = dv_reg[g] << SH;
        assign take  = rem_reg[g] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                dv_vld_reg[g+1] <= dv_vld_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1] <= take ? rem_reg[g] - trial : rem_reg[g];
                dv_reg[g+1]  <= dv_reg[g];
                q_reg[g+1]   <= {q_reg[g][DIV_N-2:0], take};
                sat_reg[g+1] <= sat_reg[g];
                dov_reg[g+1] <= dov_reg[g];
            end
        end
    end

    // output register
    logic [16:0] q_fin, diff;
    logic signed [ntcb_pkg::TEMP_W-1:0] temp_next;

    always_comb begin
        q_fin = q_reg[DIV_N];
        diff  = q_fin - ntcb_pkg::ABS_ZERO;
        if (dov_reg[DIV_N]) begin
            temp_next = ntcb_pkg::TEMP_MIN;
        end else if (sat_reg[DIV_N] || (q_fin > ntcb_pkg::Q_MAX)) begin
            temp_next = ntcb_pkg::TEMP_MAX;
        end else begin
            temp_next = $signed(diff[ntcb_pkg::TEMP_W-1:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_vld_reg[DIV_N];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg    <= temp_next;
            oor_out_reg <= dov_reg[DIV_N];
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_temperature_centi_c = temp_reg;
    assign m_out_of_range        = oor_out_reg;

endmodule

[hw/rtl/ntcb_ln.sv]
// ----------------------------------------------------------------------------
// ntcb_ln
// four-stage natural log of a positive integer, q16 result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntcb_ln (
    input  logic                             aclk,
    input  logic                             en,
    input  logic [ntcb_pkg::OHM_W-1:0]       x,
    output logic signed [ntcb_pkg::LN_W-1:0] ln_q16
);

    logic [ntcb_pkg::K_W-1:0]   k1_reg, k2_reg, k3_reg;
    logic [ntcb_pkg::M_W-1:0]   m1_reg, m2_reg;
    logic [ntcb_pkg::ACC_W-1:0] acc2_reg, acc3_reg;
    logic signed [ntcb_pkg::LN_W-1:0] ln_reg;

    logic [ntcb_pkg::OHM_W-1:0] xx;
    logic [ntcb_pkg::K_W-1:0]   k_next;
    logic [ntcb_pkg::M_W-1:0]   m1_next, m2_next;
    logic [ntcb_pkg::ACC_W-1:0] acc2_next, acc3_next;
    logic [ntcb_pkg::LN_W-1:0]  ln_next;

    // normalize
    always_comb begin
        xx     = (x == '0) ? ntcb_pkg::OHM_W'(1) : x;
        k_next = '0;
        for (int i = 0; i < ntcb_pkg::OHM_W; i++) begin
            if (xx[i]) begin
                k_next = ntcb_pkg::K_W'(i);
            end
        end
        m1_next = ntcb_pkg::M_W'({xx, 16'b0} >> k_next);
    end

    // steps 1 to 8
    always_comb begin
        logic [ntcb_pkg::M_W-1:0] m;
        logic [ntcb_pkg::M_W-1:0] t;
        logic [ntcb_pkg::ACC_W-1:0] acc;
        m   = m1_reg;
        acc = '0;
        for (int i = 1; i <= 8; i++) begin
            t = m + (m >> i);
            if (t <= ntcb_pkg::TWO_Q16) begin
                m   = t;
                acc = acc + ntcb_pkg::ln_step(i);
            end
        end
        m2_next   = m;
        acc2_next = acc;
    end

    // steps 9 to 16
    always_comb begin
        logic [ntcb_pkg::M_W-1:0] m;
        logic [ntcb_pkg::M_W-1:0] t;
        logic [ntcb_pkg::ACC_W-1:0] acc;
        m   = m2_reg;
        acc = acc2_reg;
        for (int i = 9; i <= 16; i++) begin
            t = m + (m >> i);
            if (t <= ntcb_pkg::TWO_Q16) begin
                m   = t;
                acc = acc + ntcb_pkg::ln_step(i);
            end
        end
        acc3_next = acc;
    end

    always_comb begin
        ln_next = ntcb_pkg::LN_W'(k3_reg) * ntcb_pkg::LN_W'(ntcb_pkg::LN2_Q16)
                + ntcb_pkg::LN_W'(ntcb_pkg::LN2_Q16) - ntcb_pkg::LN_W'(acc3_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg   <= k_next;
            m1_reg   <= m1_next;
            k2_reg   <= k1_reg;
            m2_reg   <= m2_next;
            acc2_reg <= acc2_next;
            k3_reg   <= k2_reg;
            acc3_reg <= acc3_next;
            ln_reg   <= $signed(ln_next);
        end
    end

    assign ln_q16 = ln_reg;

endmodule

[hw/rtl/ntcb_checker.sv]
// ----------------------------------------------------------------------------
// ntcb_checker
// port-level checks on the ntc temperature pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ntc_beta_temperature_top_macros.svh"

module ntcb_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [ntcb_pkg::TEMP_W-1:0] m_temperature_centi_c,
    input logic                               m_out_of_range
);

    `NTCB_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_temperature_centi_c) && $stable(m_out_of_range))
    `NTCB_ASSERT_NOW(a_oor_value, m_valid && m_out_of_range, m_temperature_centi_c == ntcb_pkg::TEMP_MIN)
    `NTCB_ASSERT_NOW(a_ready_flow, 1'b1, s_ready == (!m_valid || m_ready))

endmodule

bind ntc_beta_temperature_top ntcb_checker u_ntcb_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .s_ready               (s_ready),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_temperature_centi_c (m_temperature_centi_c),
    .m_out_of_range        (m_out_of_range)
);
